FILE: rtl/bip_pkg.sv
// bytecode predecoder package: opcode codes, stop reasons, record type
// and the instruction length lookup
// no dependencies
package bip_pkg;

  localparam logic [7:0] OP_NOP         = 8'h00;
  localparam logic [7:0] OP_MOVE        = 8'h01;
  localparam logic [7:0] OP_RET_NONE    = 8'h0e;
  localparam logic [7:0] OP_RET_VAL     = 8'h0f;
  localparam logic [7:0] OP_RET_PAIR    = 8'h10;
  localparam logic [7:0] OP_RET_REF     = 8'h11;
  localparam logic [7:0] OP_CONST4      = 8'h12;
  localparam logic [7:0] OP_CONST16     = 8'h13;
  localparam logic [7:0] OP_IGET        = 8'h52;
  localparam logic [7:0] OP_IPUT        = 8'h59;
  localparam logic [7:0] OP_INVOKE_VIRT = 8'h6e;
  localparam logic [7:0] OP_CALL_DIRECT = 8'h71;
  localparam logic [7:0] OP_ALU_ADD     = 8'h90;

  localparam int TDATA_BITS = 72;

  typedef enum logic [1:0] {
    STOP_CLEAN   = 2'd0,
    STOP_ODD     = 2'd1,
    STOP_UNKNOWN = 2'd2,
    STOP_TRUNC   = 2'd3
  } stop_t;

  typedef enum logic {
    KIND_INSN    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         opcode;
    logic [3:0]         reg_high;
    logic [3:0]         reg_low;
    logic signed [16:0] immediate;
    logic [15:0]        bytes_consumed;
    logic [14:0]        instruction_total;
    stop_t              stop_reason;
    logic               last;
  } rec_t;

  // zero marks an opcode outside the supported set
  function automatic logic [2:0] insn_length(input logic [7:0] op);
    logic [2:0] len;
    case (op) inside
      OP_NOP, OP_MOVE, OP_RET_NONE, OP_RET_VAL, OP_RET_PAIR,
      OP_RET_REF, OP_CONST4, OP_ALU_ADD: len = 3'd2;
      OP_CONST16, OP_IGET, OP_IPUT:      len = 3'd4;
      OP_INVOKE_VIRT, OP_CALL_DIRECT:    len = 3'd6;
      default:                           len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/bip_core.sv
// bytecode predecoder core: per-byte decode state, counters and record build
// depends on bip_pkg
module bip_core
  import bip_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] code_byte,
  input  logic       end_of_code,
  output rec_t       rec_first,
  output rec_t       rec_second,
  output logic [1:0] rec_count
);

  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  logic [2:0]    pos, pos_next;
  logic [7:0]    held_opcode, held_opcode_next;
  logic [7:0]    held_unit, held_unit_next;
  logic [7:0]    held_imm_low, held_imm_low_next;
  logic [7:0]    held_imm_high, held_imm_high_next;
  logic          stopped, stopped_next;
  stop_t         stop_code, stop_code_next;
  logic [CW-1:0] consumed, consumed_next;
  logic [14:0]   decoded, decoded_next;

  logic [2:0]    len_cur, len_held, pos_inc;
  logic [7:0]    unit_eff, lo_eff, hi_eff;
  logic          complete;
  logic [CW:0]   consumed_sum;
  logic [CW-1:0] consumed_upd;
  logic [14:0]   decoded_upd;
  logic signed [16:0] imm;
  stop_t         reason;
  rec_t          insn_rec, summary_rec;

  assign len_cur  = insn_length(code_byte);
  assign len_held = insn_length(held_opcode);
  assign pos_inc  = pos + 3'd1;

  assign unit_eff = (pos == 3'd1) ? code_byte : held_unit;
  assign lo_eff   = (pos == 3'd2) ? code_byte : held_imm_low;
  assign hi_eff   = (pos == 3'd3) ? code_byte : held_imm_high;

  assign complete = !stopped && (pos != 3'd0) && (pos_inc >= len_held);

  assign consumed_sum = {1'b0, consumed} + {{(CW-2){1'b0}}, len_held};
  assign consumed_upd = consumed_sum[CW] ? {CW{1'b1}} : consumed_sum[CW-1:0];
  assign decoded_upd  = (decoded == 15'h7fff) ? decoded : decoded + 15'd1;

  always_comb begin
    case (held_opcode) inside
      OP_CONST4:                                     imm = {{13{unit_eff[3]}}, unit_eff[3:0]};
      OP_CONST16:                                    imm = {hi_eff[7], hi_eff, lo_eff};
      OP_IGET, OP_IPUT, OP_INVOKE_VIRT, OP_CALL_DIRECT: imm = {1'b0, hi_eff, lo_eff};
      default:                                       imm = 17'sd0;
    endcase
  end

  always_comb begin
    if (stopped) begin
      reason = stop_code;
    end else if (pos == 3'd0) begin
      reason = STOP_ODD;
    end else if (complete) begin
      reason = STOP_CLEAN;
    end else begin
      reason = STOP_TRUNC;
    end
  end

  // next state
  always_comb begin
    pos_next           = pos;
    held_opcode_next   = held_opcode;
    held_unit_next     = held_unit;
    held_imm_low_next  = held_imm_low;
    held_imm_high_next = held_imm_high;
    stopped_next       = stopped;
    stop_code_next     = stop_code;
    consumed_next      = consumed;
    decoded_next       = decoded;
    if (end_of_code) begin
      pos_next           = 3'd0;
      held_opcode_next   = 8'd0;
      held_unit_next     = 8'd0;
      held_imm_low_next  = 8'd0;
      held_imm_high_next = 8'd0;
      stopped_next       = 1'b0;
      stop_code_next     = STOP_CLEAN;
      consumed_next      = '0;
      decoded_next       = 15'd0;
    end else if (!stopped) begin
      if (pos == 3'd0) begin
        if (len_cur == 3'd0) begin
          stopped_next   = 1'b1;
          stop_code_next = STOP_UNKNOWN;
        end else begin
          held_opcode_next = code_byte;
          pos_next         = 3'd1;
        end
      end else begin
        held_unit_next     = unit_eff;
        held_imm_low_next  = lo_eff;
        held_imm_high_next = hi_eff;
        if (complete) begin
          pos_next      = 3'd0;
          consumed_next = consumed_upd;
          decoded_next  = decoded_upd;
        end else begin
          pos_next = pos_inc;
        end
      end
    end
  end

  // record build
  always_comb begin
    insn_rec.kind              = KIND_INSN;
    insn_rec.opcode            = held_opcode;
    insn_rec.reg_high          = unit_eff[7:4];
    insn_rec.reg_low           = unit_eff[3:0];
    insn_rec.immediate         = imm;
    insn_rec.bytes_consumed    = 16'(consumed_upd);
    insn_rec.instruction_total = decoded_upd;
    insn_rec.stop_reason       = STOP_CLEAN;
    insn_rec.last              = !end_of_code;

    summary_rec.kind              = KIND_SUMMARY;
    summary_rec.opcode            = 8'd0;
    summary_rec.reg_high          = 4'd0;
    summary_rec.reg_low           = 4'd0;
    summary_rec.immediate         = 17'sd0;
    summary_rec.bytes_consumed    = complete ? 16'(consumed_upd) : 16'(consumed);
    summary_rec.instruction_total = complete ? decoded_upd : decoded;
    summary_rec.stop_reason       = reason;
    summary_rec.last              = 1'b1;
  end

  assign rec_first  = complete ? insn_rec : summary_rec;
  assign rec_second = summary_rec;
  assign rec_count  = {1'b0, complete} + {1'b0, end_of_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      stopped   <= 1'b0;
      stop_code <= STOP_CLEAN;
      consumed  <= '0;
      decoded   <= 15'd0;
      held_opcode   <= 8'd0;
      held_unit     <= 8'd0;
      held_imm_low  <= 8'd0;
      held_imm_high <= 8'd0;
    end else if (accept) begin
      pos       <= pos_next;
      stopped   <= stopped_next;
      stop_code <= stop_code_next;
      consumed  <= consumed_next;
      decoded   <= decoded_next;
      held_opcode   <= held_opcode_next;
      held_unit     <= held_unit_next;
      held_imm_low  <= held_imm_low_next;
      held_imm_high <= held_imm_high_next;
    end
  end

endmodule

FILE: rtl/bytecode_instruction_predecoder.sv
// Bytecode instruction predecoder, top level: byte stream in, decoded
// instruction and summary words out. Depends on bip_pkg and bip_core.
// One byte is taken per cycle unless the result buffer holds the input.
// Each byte gives zero, one or two words in the cycle after it is taken;
// words wait in a two-entry result buffer, so a byte that gives one word
// never stalls the input while the sink keeps up. A final byte that also
// completes an instruction gives two words and holds the input while the
// buffer drains. No clearing pass after reset.
module bytecode_instruction_predecoder
  import bip_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // code_byte
  input  logic                  s_axis_tlast,  // end_of_code
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // opcode, reg_high, reg_low, immediate, bytes_consumed, instruction_total,
  // stop_reason, zero fill
  output logic [TDATA_BITS-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // record_kind
  output logic                  m_axis_tlast   // last_of_run
);

  rec_t       rec_first, rec_second;
  logic [1:0] rec_count;
  rec_t       q0, q1;
  logic [1:0] cnt;
  logic       accept, pop;

  assign s_axis_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = (cnt != 2'd0) && m_axis_tready;

  bip_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .code_byte   (s_axis_tdata),
    .end_of_code (s_axis_tlast),
    .rec_first   (rec_first),
    .rec_second  (rec_second),
    .rec_count   (rec_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= rec_count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q0 <= rec_first;
      q1 <= rec_second;
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tuser  = q0.kind;
  assign m_axis_tlast  = q0.last;
  assign m_axis_tdata  = {6'd0, q0.stop_reason, q0.instruction_total, q0.bytes_consumed,
                          q0.immediate, q0.reg_low, q0.reg_high, q0.opcode};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !s_axis_tready)
    else $error("input taken with full result buffer");

  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("summary word without last flag");

  a_final_byte_gives_word: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
    else $error("final byte gave no word");

  a_insn_reason_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[65:64] == 2'd0))
    else $error("instruction word with stop reason");

endmodule
